// ===== rtl/spi_nor_flash_command_sequencer_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SNFCS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define SNFCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/snfcs_pkg.sv =====
package snfcs_pkg;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_DATA  = 2'd1,
		ACT_REPLY = 2'd2,
		ACT_BAD   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_PROGRAM = 2'd1,
		OP_ERASE   = 2'd2,
		OP_IDENT   = 2'd3
	} operation_t;

	typedef enum logic [2:0] {
		K_SEND   = 3'd0,
		K_DESEL  = 3'd1,
		K_READ   = 3'd2,
		K_IDENT  = 3'd3,
		K_DONE   = 3'd4,
		K_REJECT = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_READ_WAIT,
		PH_PROG_DATA,
		PH_PROG_POLL,
		PH_ERASE_ACK,
		PH_ERASE_POLL,
		PH_IDENT_WAIT
	} phase_t;

	// Frame sequences the back end expands into results
	typedef enum logic [4:0] {
		SQ_READ_START,
		SQ_READ_EMPTY,
		SQ_PAGE,
		SQ_DESEL_PAGE,
		SQ_SECTOR,
		SQ_DESEL_SECTOR,
		SQ_DONE,
		SQ_DESEL_DONE,
		SQ_IDENT_START,
		SQ_DATA,
		SQ_DATA_POLL,
		SQ_READ_MORE,
		SQ_READ_END,
		SQ_FILLER,
		SQ_POLL,
		SQ_IDENT_END,
		SQ_REJECT
	} seq_t;

	// Register indexes
	localparam logic [2:0] R_PROGRAM = 3'd0;
	localparam logic [2:0] R_READ    = 3'd1;
	localparam logic [2:0] R_ENABLE  = 3'd2;
	localparam logic [2:0] R_STATUS  = 3'd3;
	localparam logic [2:0] R_ERASE   = 3'd4;
	localparam logic [2:0] R_IDENT   = 3'd5;
	localparam logic [2:0] R_FILLER  = 3'd6;
	localparam logic [2:0] R_BUSY    = 3'd7;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  operation;
		logic [23:0] address;
		logic [15:0] length;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  mosi_byte;
		logic        expects_reply;
		logic [23:0] host_value;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [7:0] program_opcode;
		logic [7:0] read_opcode;
		logic [7:0] enable_opcode;
		logic [7:0] status_opcode;
		logic [7:0] erase_opcode;
		logic [7:0] ident_opcode;
		logic [7:0] filler_byte;
		logic [7:0] busy_mask;
	} cfg_t;

	typedef struct packed {
		seq_t        seq;
		logic [23:0] addr;
		logic [23:0] value;
	} desc_t;

	function automatic rsp_t mk(kind_t k, logic [7:0] b, logic r, logic [23:0] h, logic l);
		rsp_t x;
		x.kind          = k;
		x.mosi_byte     = b;
		x.expects_reply = r;
		x.host_value    = h;
		x.last          = l;
		return x;
	endfunction

	function automatic rsp_t send(logic [7:0] b, logic r, logic l);
		return mk(K_SEND, b, r, 24'd0, l);
	endfunction

	function automatic rsp_t plain(kind_t k, logic l);
		return mk(k, 8'd0, 1'b0, 24'd0, l);
	endfunction

	// Write enable, command byte and address; erase waits on the last address byte
	function automatic rsp_t cmd_frame(logic [2:0] st, logic [23:0] a, logic [7:0] en,
			logic [7:0] op, logic erase);
		rsp_t x;
		case (st)
			3'd0: x = send(en, 1'b0, 1'b0);
			3'd1: x = plain(K_DESEL, 1'b0);
			3'd2: x = send(op, 1'b0, 1'b0);
			3'd3: x = send(a[23:16], 1'b0, 1'b0);
			3'd4: x = send(a[15:8], 1'b0, 1'b0);
			3'd5: x = send(a[7:0], erase, 1'b1);
			default: x = plain(K_REJECT, 1'b1);
		endcase
		return x;
	endfunction

	// Deselect, status command, filler awaiting the status reply
	function automatic rsp_t poll_frame(logic [2:0] st, cfg_t c);
		rsp_t x;
		case (st)
			3'd0: x = plain(K_DESEL, 1'b0);
			3'd1: x = send(c.status_opcode, 1'b0, 1'b0);
			3'd2: x = send(c.filler_byte, 1'b1, 1'b1);
			default: x = plain(K_REJECT, 1'b1);
		endcase
		return x;
	endfunction

	function automatic rsp_t read_head(logic [2:0] st, logic [23:0] a, cfg_t c, logic empty);
		rsp_t x;
		case (st)
			3'd0: x = send(c.read_opcode, 1'b0, 1'b0);
			3'd1: x = send(a[23:16], 1'b0, 1'b0);
			3'd2: x = send(a[15:8], 1'b0, 1'b0);
			3'd3: x = send(a[7:0], 1'b0, 1'b0);
			3'd4: x = empty ? plain(K_DESEL, 1'b0) : send(c.filler_byte, 1'b1, 1'b1);
			3'd5: x = plain(K_DONE, 1'b1);
			default: x = plain(K_REJECT, 1'b1);
		endcase
		return x;
	endfunction

	// One result of a sequence, selected by step
	function automatic rsp_t expand(desc_t d, logic [2:0] st, cfg_t c);
		rsp_t x;
		logic [2:0] sm1;
		sm1 = st - 3'd1;
		case (d.seq)
			SQ_READ_START: x = read_head(st, d.addr, c, 1'b0);
			SQ_READ_EMPTY: x = read_head(st, d.addr, c, 1'b1);
			SQ_PAGE: x = cmd_frame(st, d.addr, c.enable_opcode, c.program_opcode, 1'b0);
			SQ_DESEL_PAGE: x = (st == 3'd0) ? plain(K_DESEL, 1'b0) :
				cmd_frame(sm1, d.addr, c.enable_opcode, c.program_opcode, 1'b0);
			SQ_SECTOR: x = cmd_frame(st, d.addr, c.enable_opcode, c.erase_opcode, 1'b1);
			SQ_DESEL_SECTOR: x = (st == 3'd0) ? plain(K_DESEL, 1'b0) :
				cmd_frame(sm1, d.addr, c.enable_opcode, c.erase_opcode, 1'b1);
			SQ_DONE: x = plain(K_DONE, 1'b1);
			SQ_DESEL_DONE: x = (st == 3'd0) ? plain(K_DESEL, 1'b0) : plain(K_DONE, 1'b1);
			SQ_IDENT_START: x = (st == 3'd0) ? send(c.ident_opcode, 1'b0, 1'b0) :
				send(c.filler_byte, 1'b1, 1'b1);
			SQ_DATA: x = send(d.value[7:0], 1'b0, 1'b1);
			SQ_DATA_POLL: x = (st == 3'd0) ? send(d.value[7:0], 1'b0, 1'b0) :
				poll_frame(sm1, c);
			SQ_READ_MORE: x = (st == 3'd0) ? mk(K_READ, 8'd0, 1'b0, d.value, 1'b0) :
				send(c.filler_byte, 1'b1, 1'b1);
			SQ_READ_END: begin
				case (st)
					3'd0: x = mk(K_READ, 8'd0, 1'b0, d.value, 1'b0);
					3'd1: x = plain(K_DESEL, 1'b0);
					default: x = plain(K_DONE, 1'b1);
				endcase
			end
			SQ_FILLER: x = send(c.filler_byte, 1'b1, 1'b1);
			SQ_POLL: x = poll_frame(st, c);
			SQ_IDENT_END: x = (st == 3'd0) ? plain(K_DESEL, 1'b0) :
				mk(K_IDENT, 8'd0, 1'b0, d.value, 1'b1);
			default: x = plain(K_REJECT, 1'b1);
		endcase
		return x;
	endfunction

endpackage

// ===== rtl/snfcs_front.sv =====
module snfcs_front #(
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  snfcs_pkg::req_t req,
	input  snfcs_pkg::cfg_t cfg,
	output snfcs_pkg::desc_t desc
);
	import snfcs_pkg::*;

	localparam int PW = $clog2(PAGE_BYTES) + 1;

	phase_t       phase_q, phase_d;
	logic [23:0]  addr_q, addr_d;
	logic [15:0]  rem_q, rem_d;
	logic [PW-1:0] page_q, page_d;
	logic [23:0]  acc_q, acc_d;
	logic [1:0]   seen_q, seen_d;
	seq_t         seq;
	logic [23:0]  value;

	logic [PW-1:0] room_new, room_cur, pl_m1;
	logic [15:0]   rem_m1;
	logic [23:0]   acc_sh;
	logic [1:0]    seen_p1;
	logic          busy;

	assign room_new = PW'(PAGE_BYTES) - {1'b0, req.address[PW-2:0]};
	assign room_cur = PW'(PAGE_BYTES) - {1'b0, addr_q[PW-2:0]};
	assign pl_m1    = page_q - PW'(1);
	assign rem_m1   = rem_q - 16'd1;
	assign acc_sh   = {acc_q[15:0], req.data_byte};
	assign seen_p1  = seen_q + 2'd1;
	assign busy     = (req.data_byte & cfg.busy_mask) != 8'd0;

	// Classify the item into a frame sequence and update the datapath state
	always_comb begin
		seq    = SQ_REJECT;
		value  = {16'd0, req.data_byte};
		addr_d = addr_q;
		rem_d  = rem_q;
		page_d = page_q;
		acc_d  = acc_q;
		seen_d = seen_q;
		if (req.action == ACT_START && phase_q == PH_IDLE) begin
			addr_d = req.address;
			rem_d  = req.length;
			case (req.operation)
				OP_READ: seq = (req.length == 16'd0) ? SQ_READ_EMPTY : SQ_READ_START;
				OP_PROGRAM: begin
					seq = (req.length == 16'd0) ? SQ_DONE : SQ_PAGE;
					page_d = (req.length < {{(16-PW){1'b0}}, room_new}) ?
						req.length[PW-1:0] : room_new;
				end
				OP_ERASE: seq = (req.length == 16'd0) ? SQ_DONE : SQ_SECTOR;
				default: begin
					seq    = SQ_IDENT_START;
					acc_d  = 24'd0;
					seen_d = 2'd0;
				end
			endcase
		end else if (req.action == ACT_DATA && phase_q == PH_PROG_DATA) begin
			page_d = pl_m1;
			rem_d  = rem_m1;
			addr_d = addr_q + 24'd1;
			seq    = (pl_m1 == '0) ? SQ_DATA_POLL : SQ_DATA;
		end else if (req.action == ACT_REPLY) begin
			case (phase_q)
				PH_READ_WAIT: begin
					rem_d = rem_m1;
					seq   = (rem_m1 != 16'd0) ? SQ_READ_MORE : SQ_READ_END;
				end
				PH_PROG_POLL: begin
					if (busy) begin
						seq = SQ_FILLER;
					end else if (rem_q == 16'd0) begin
						seq = SQ_DESEL_DONE;
					end else begin
						seq = SQ_DESEL_PAGE;
						page_d = (rem_q < {{(16-PW){1'b0}}, room_cur}) ?
							rem_q[PW-1:0] : room_cur;
					end
				end
				PH_ERASE_ACK: seq = SQ_POLL;
				PH_ERASE_POLL: begin
					if (busy) begin
						seq = SQ_FILLER;
					end else begin
						rem_d  = rem_m1;
						addr_d = addr_q + 24'(SECTOR_BYTES);
						seq    = (rem_m1 == 16'd0) ? SQ_DESEL_DONE : SQ_DESEL_SECTOR;
					end
				end
				PH_IDENT_WAIT: begin
					acc_d  = acc_sh;
					seen_d = seen_p1;
					value  = acc_sh;
					seq    = (seen_p1 < 2'd3) ? SQ_FILLER : SQ_IDENT_END;
				end
				default: seq = SQ_REJECT;
			endcase
		end
	end

	// Advance the phase from the chosen sequence
	always_comb begin
		case (seq)
			SQ_READ_START:   phase_d = PH_READ_WAIT;
			SQ_PAGE, SQ_DESEL_PAGE: phase_d = PH_PROG_DATA;
			SQ_DATA_POLL:    phase_d = PH_PROG_POLL;
			SQ_SECTOR, SQ_DESEL_SECTOR: phase_d = PH_ERASE_ACK;
			SQ_POLL:         phase_d = PH_ERASE_POLL;
			SQ_IDENT_START:  phase_d = PH_IDENT_WAIT;
			SQ_READ_EMPTY, SQ_DONE, SQ_DESEL_DONE, SQ_READ_END, SQ_IDENT_END:
				phase_d = PH_IDLE;
			default:         phase_d = phase_q;
		endcase
	end

	assign desc.seq   = seq;
	assign desc.addr  = addr_d;
	assign desc.value = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			rem_q   <= '0;
			page_q  <= '0;
			acc_q   <= '0;
			seen_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			rem_q   <= rem_d;
			page_q  <= page_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
		end
	end

endmodule

// ===== rtl/snfcs_queue.sv =====
module snfcs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  snfcs_pkg::desc_t wdata,
	output logic             full,
	input  logic             rd,
	output logic             valid,
	output snfcs_pkg::desc_t rdata
);
	import snfcs_pkg::*;

	desc_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem[rp_q];

	// Store on write
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= wdata;
		end
	end

	// Advance pointers and hold the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
		end
	end

endmodule

// ===== rtl/snfcs_back.sv =====
module snfcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             qvalid,
	input  snfcs_pkg::desc_t qdata,
	output logic             qpop,
	input  snfcs_pkg::cfg_t  cfg,
	output logic             empty,
	input  logic             pop,
	output snfcs_pkg::rsp_t  rsp
);
	import snfcs_pkg::*;

	logic [2:0] step_q;
	logic       vld_q;
	rsp_t       out_q;
	rsp_t       nxt;
	logic       load;

	assign nxt   = expand(qdata, step_q, cfg);
	assign load  = qvalid && (!vld_q || pop);
	assign qpop  = load && nxt.last;
	assign empty = !vld_q;
	assign rsp   = out_q;

	// Step through the sequence, one result per transfer slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (load) step_q <= nxt.last ? 3'd0 : step_q + 3'd1;
			if (load) vld_q <= 1'b1;
			else if (pop) vld_q <= 1'b0;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (load) out_q <= nxt;
	end

endmodule

// ===== rtl/spi_nor_flash_command_sequencer.sv =====
// Channel   Handshake        Payload
// request   push / full      req  (action, operation, address, length, data_byte)
// result    pop / empty      rsp  (kind, mosi_byte, expects_reply, host_value, last)
// config    APB psel/penable paddr, pwdata, prdata (eight 8-bit registers)
//
// An item is classified in the cycle it is accepted; a request may enter every
// cycle while the descriptor queue (four entries) has room.
// The expander emits one result per cycle while results are popped; an item expands
// into 1 to 7 results, as set by the sequence stepper in the back end.
// Reset returns the phase to idle and registers to their defaults.
// A stalled result holds both sides once the queue fills.
module spi_nor_flash_command_sequencer #(
	parameter int PAGE_BYTES   = 256,
	parameter int SECTOR_BYTES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  snfcs_pkg::req_t req,
	output logic            empty,
	input  logic            pop,
	output snfcs_pkg::rsp_t rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import snfcs_pkg::*;

	cfg_t       cfg_q;
	desc_t      fdesc, qdesc;
	logic       take, qvalid, qpop;
	logic [2:0] ridx;
	logic [7:0] rval;

	assign take   = push && !full;
	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.program_opcode <= 8'h02;
			cfg_q.read_opcode    <= 8'h03;
			cfg_q.enable_opcode  <= 8'h06;
			cfg_q.status_opcode  <= 8'h05;
			cfg_q.erase_opcode   <= 8'h20;
			cfg_q.ident_opcode   <= 8'h9F;
			cfg_q.filler_byte    <= 8'hFF;
			cfg_q.busy_mask      <= 8'h01;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				R_PROGRAM: cfg_q.program_opcode <= pwdata[7:0];
				R_READ:    cfg_q.read_opcode    <= pwdata[7:0];
				R_ENABLE:  cfg_q.enable_opcode  <= pwdata[7:0];
				R_STATUS:  cfg_q.status_opcode  <= pwdata[7:0];
				R_ERASE:   cfg_q.erase_opcode   <= pwdata[7:0];
				R_IDENT:   cfg_q.ident_opcode   <= pwdata[7:0];
				R_FILLER:  cfg_q.filler_byte    <= pwdata[7:0];
				default:   cfg_q.busy_mask      <= pwdata[7:0];
			endcase
		end
	end

	// Read back
	always_comb begin
		case (ridx)
			R_PROGRAM: rval = cfg_q.program_opcode;
			R_READ:    rval = cfg_q.read_opcode;
			R_ENABLE:  rval = cfg_q.enable_opcode;
			R_STATUS:  rval = cfg_q.status_opcode;
			R_ERASE:   rval = cfg_q.erase_opcode;
			R_IDENT:   rval = cfg_q.ident_opcode;
			R_FILLER:  rval = cfg_q.filler_byte;
			default:   rval = cfg_q.busy_mask;
		endcase
	end
	assign prdata = {24'd0, rval};

	snfcs_front #(
		.PAGE_BYTES   (PAGE_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req),
		.cfg    (cfg_q),
		.desc   (fdesc)
	);

	snfcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wdata  (fdesc),
		.full   (full),
		.rd     (qpop),
		.valid  (qvalid),
		.rdata  (qdesc)
	);

	snfcs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qvalid (qvalid),
		.qdata  (qdesc),
		.qpop   (qpop),
		.cfg    (cfg_q),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/snfcs_checker.sv =====
`include "spi_nor_flash_command_sequencer_macros.svh"

module snfcs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            empty,
	input logic            pop,
	input snfcs_pkg::rsp_t rsp,
	input logic            pready
);
	import snfcs_pkg::*;

	// A waiting result holds until taken
	`SNFCS_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(rsp))
	// Only sent bytes wait for a reply
	`SNFCS_ASSERT(a_reply, clk, arst_n, empty || !rsp.expects_reply || rsp.kind == K_SEND)
	// Non-send results carry no byte
	`SNFCS_ASSERT(a_mosi, clk, arst_n, empty || rsp.kind == K_SEND || rsp.mosi_byte == 8'd0)
	// Done, identifier and rejected always close an item
	`SNFCS_ASSERT(a_close, clk, arst_n,
		empty || !(rsp.kind == K_DONE || rsp.kind == K_IDENT || rsp.kind == K_REJECT) ||
		rsp.last)
	`SNFCS_ASSERT(a_ready, clk, arst_n, pready)

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.rsp    (rsp),
	.pready (pready)
);

// ===== tb/spi_nor_flash_command_sequencer_test.sv =====
module spi_nor_flash_command_sequencer_test;
	import snfcs_pkg::*;

	localparam int PAGE = 256;
	localparam int SECTOR = 4096;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	spi_nor_flash_command_sequencer u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Flash command state mirrored by the testbench
	cfg_t cfg;
	phase_t ph;
	logic [23:0] faddr;
	logic [15:0] remain;
	logic [12:0] page_left;
	logic [23:0] ident_acc;
	logic [1:0] ident_cnt;

	rsp_t frames_due[$];
	int mismatches = 0;
	int transfers = 0;
	int results_seen = 0;
	int cycles = 0;
	bit idle_off = 1'b0;
	int pages_done = 0;
	int sectors_done = 0;
	int idents_done = 0;

	function automatic rsp_t frame(kind_t k, logic [7:0] b, logic r, logic [23:0] h);
		rsp_t x;
		x.kind = k;
		x.mosi_byte = b;
		x.expects_reply = r;
		x.host_value = h;
		x.last = 1'b0;
		return x;
	endfunction

	function automatic void add_addr(logic [23:0] a, logic r);
		frames_due.push_back(frame(K_SEND, a[23:16], 1'b0, '0));
		frames_due.push_back(frame(K_SEND, a[15:8], 1'b0, '0));
		frames_due.push_back(frame(K_SEND, a[7:0], r, '0));
	endfunction

	function automatic void open_page();
		int room;
		room = PAGE - (faddr % PAGE);
		page_left = 13'((remain < room) ? remain : room);
		frames_due.push_back(frame(K_SEND, cfg.enable_opcode, 1'b0, '0));
		frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
		frames_due.push_back(frame(K_SEND, cfg.program_opcode, 1'b0, '0));
		add_addr(faddr, 1'b0);
		ph = PH_PROG_DATA;
	endfunction

	function automatic void open_sector();
		frames_due.push_back(frame(K_SEND, cfg.enable_opcode, 1'b0, '0));
		frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
		frames_due.push_back(frame(K_SEND, cfg.erase_opcode, 1'b0, '0));
		add_addr(faddr, 1'b1);
		ph = PH_ERASE_ACK;
	endfunction

	function automatic void open_poll();
		frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
		frames_due.push_back(frame(K_SEND, cfg.status_opcode, 1'b0, '0));
		frames_due.push_back(frame(K_SEND, cfg.filler_byte, 1'b1, '0));
	endfunction

	// Work out the frames one accepted request produces
	function automatic void predict_frames(req_t r);
		int first;
		first = frames_due.size();
		if (r.action == ACT_START && ph == PH_IDLE) begin
			faddr = r.address;
			remain = r.length;
			case (r.operation)
				OP_READ: begin
					frames_due.push_back(frame(K_SEND, cfg.read_opcode, 1'b0, '0));
					add_addr(r.address, 1'b0);
					if (r.length == 0) begin
						frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
						frames_due.push_back(frame(K_DONE, 8'd0, 1'b0, '0));
					end else begin
						frames_due.push_back(frame(K_SEND, cfg.filler_byte, 1'b1, '0));
						ph = PH_READ_WAIT;
					end
				end
				OP_PROGRAM, OP_ERASE: begin
					if (r.length == 0)
						frames_due.push_back(frame(K_DONE, 8'd0, 1'b0, '0));
					else if (r.operation == OP_PROGRAM)
						open_page();
					else
						open_sector();
				end
				default: begin
					ident_acc = '0;
					ident_cnt = '0;
					frames_due.push_back(frame(K_SEND, cfg.ident_opcode, 1'b0, '0));
					frames_due.push_back(frame(K_SEND, cfg.filler_byte, 1'b1, '0));
					ph = PH_IDENT_WAIT;
				end
			endcase
		end else if (r.action == ACT_DATA && ph == PH_PROG_DATA) begin
			frames_due.push_back(frame(K_SEND, r.data_byte, 1'b0, '0));
			page_left--;
			remain--;
			faddr++;
			if (page_left == 0) begin
				open_poll();
				ph = PH_PROG_POLL;
			end
		end else if (r.action == ACT_REPLY && ph == PH_READ_WAIT) begin
			frames_due.push_back(frame(K_READ, 8'd0, 1'b0, {16'd0, r.data_byte}));
			remain--;
			if (remain != 0) begin
				frames_due.push_back(frame(K_SEND, cfg.filler_byte, 1'b1, '0));
			end else begin
				frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
				frames_due.push_back(frame(K_DONE, 8'd0, 1'b0, '0));
				ph = PH_IDLE;
			end
		end else if (r.action == ACT_REPLY && ph == PH_PROG_POLL) begin
			if ((r.data_byte & cfg.busy_mask) != 0) begin
				frames_due.push_back(frame(K_SEND, cfg.filler_byte, 1'b1, '0));
			end else begin
				frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
				pages_done++;
				if (remain == 0) begin
					frames_due.push_back(frame(K_DONE, 8'd0, 1'b0, '0));
					ph = PH_IDLE;
				end else begin
					open_page();
				end
			end
		end else if (r.action == ACT_REPLY && ph == PH_ERASE_ACK) begin
			open_poll();
			ph = PH_ERASE_POLL;
		end else if (r.action == ACT_REPLY && ph == PH_ERASE_POLL) begin
			if ((r.data_byte & cfg.busy_mask) != 0) begin
				frames_due.push_back(frame(K_SEND, cfg.filler_byte, 1'b1, '0));
			end else begin
				frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
				sectors_done++;
				remain--;
				faddr = 24'(faddr + SECTOR);
				if (remain == 0) begin
					frames_due.push_back(frame(K_DONE, 8'd0, 1'b0, '0));
					ph = PH_IDLE;
				end else begin
					open_sector();
				end
			end
		end else if (r.action == ACT_REPLY && ph == PH_IDENT_WAIT) begin
			ident_acc = {ident_acc[15:0], r.data_byte};
			ident_cnt++;
			if (ident_cnt < 3) begin
				frames_due.push_back(frame(K_SEND, cfg.filler_byte, 1'b1, '0));
			end else begin
				frames_due.push_back(frame(K_DESEL, 8'd0, 1'b0, '0));
				frames_due.push_back(frame(K_IDENT, 8'd0, 1'b0, ident_acc));
				idents_done++;
				ph = PH_IDLE;
			end
		end else begin
			frames_due.push_back(frame(K_REJECT, 8'd0, 1'b0, '0));
		end
		if (frames_due.size() > first)
			frames_due[frames_due.size() - 1].last = 1'b1;
	endfunction

	// Drive one transfer and predict its frames once accepted; push stays
	// high into the next call so transfers can follow back to back
	task automatic send_request(req_t r);
		@(negedge clk);
		if (!idle_off && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		push <= 1'b1;
		req <= r;
		do @(posedge clk); while (full);
		predict_frames(r);
		transfers++;
	endtask

	task automatic send_fields(action_t a, operation_t o, logic [23:0] ad,
			logic [15:0] len, logic [7:0] d);
		req_t r;
		r.action = a;
		r.operation = o;
		r.address = ad;
		r.length = len;
		r.data_byte = d;
		send_request(r);
	endtask

	// Stall the result side now and then
	always @(negedge clk) begin
		if (!idle_off && $urandom_range(0, 4) == 0) begin
			pop <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare each popped result with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		cycles++;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d mosi=%h", rsp.kind, rsp.mosi_byte);
			end else begin
				want = frames_due.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: exp k%0d m%h r%b h%h l%b got k%0d m%h r%b h%h l%b",
							results_seen, want.kind, want.mosi_byte, want.expects_reply,
							want.host_value, want.last, rsp.kind, rsp.mosi_byte,
							rsp.expects_reply, rsp.host_value, rsp.last);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Drop push and wait until every predicted result has been taken
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Read back the register just written
		if (prdata !== {24'd0, v}) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %0d: exp %h got %h", idx, v, prdata);
		end
		case (idx)
			R_PROGRAM: cfg.program_opcode = v;
			R_READ: cfg.read_opcode = v;
			R_ENABLE: cfg.enable_opcode = v;
			R_STATUS: cfg.status_opcode = v;
			R_ERASE: cfg.erase_opcode = v;
			R_IDENT: cfg.ident_opcode = v;
			R_FILLER: cfg.filler_byte = v;
			default: cfg.busy_mask = v;
		endcase
	endtask

	task automatic set_all_regs(logic [7:0] base);
		for (int i = 0; i < 8; i++)
			write_reg(i[2:0], base ^ 8'(i * 37));
		write_reg(R_BUSY, 8'($urandom_range(1, 255)));
	endtask

	// Answer outstanding replies until the block is idle again
	task automatic finish_sequence();
		int guard;
		guard = 0;
		while (ph != PH_IDLE && guard < 200) begin
			guard++;
			if (ph == PH_PROG_DATA)
				send_fields(ACT_DATA, OP_READ, '0, '0, 8'($urandom));
			else
				send_fields(ACT_REPLY, OP_READ, '0, '0,
					($urandom_range(0, 2) == 0) ? 8'hFF : 8'h00);
		end
		if (ph != PH_IDLE) begin
			// Force idle via a clear status so the sequence ends
			while (ph != PH_IDLE)
				send_fields(ph == PH_PROG_DATA ? ACT_DATA : ACT_REPLY, OP_READ, '0, '0, 8'h00);
		end
	endtask

	task automatic test_directed();
		send_fields(ACT_START, OP_READ, 24'hFFFFFF, 16'd0, 8'h00);
		send_fields(ACT_START, OP_PROGRAM, 24'h000000, 16'd0, 8'h00);
		send_fields(ACT_START, OP_ERASE, 24'hABCDEF, 16'd0, 8'h00);
		send_fields(ACT_BAD, OP_IDENT, 24'hFFFFFF, 16'hFFFF, 8'hFF);
		send_fields(ACT_DATA, OP_READ, '0, '0, 8'h55);
		send_fields(ACT_REPLY, OP_READ, '0, '0, 8'hAA);
		send_fields(ACT_START, OP_READ, 24'hFFFFFF, 16'd2, 8'h00);
		send_fields(ACT_START, OP_READ, '0, '0, 8'h00);
		send_fields(ACT_REPLY, OP_READ, '0, '0, 8'hFF);
		send_fields(ACT_REPLY, OP_READ, '0, '0, 8'h00);
		send_fields(ACT_START, OP_IDENT, '0, '0, 8'h00);
		send_fields(ACT_REPLY, OP_READ, '0, '0, 8'hEF);
		send_fields(ACT_REPLY, OP_READ, '0, '0, 8'h40);
		send_fields(ACT_REPLY, OP_READ, '0, '0, 8'h15);
		// program crossing a page boundary and an erase wrapping the address
		send_fields(ACT_START, OP_PROGRAM, 24'hFFFFFE, 16'd4, 8'h00);
		finish_sequence();
		send_fields(ACT_START, OP_ERASE, 24'hFFF000, 16'd2, 8'h00);
		finish_sequence();
		drain();
	endtask

	task automatic test_random(int n);
		int cnt;
		operation_t o;
		logic [15:0] len;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 9) == 0) begin
				send_fields(action_t'($urandom_range(0, 3)), operation_t'($urandom_range(0, 3)),
					24'($urandom), 16'($urandom_range(0, 6)), 8'($urandom));
				cnt++;
			end else begin
				o = operation_t'($urandom_range(0, 3));
				len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 40))
					: 16'($urandom_range(0, 6));
				if (o == OP_ERASE && len > 4) len = 16'($urandom_range(1, 3));
				send_fields(ACT_START, o, 24'($urandom), len, 8'($urandom));
				cnt++;
				while (ph != PH_IDLE && cnt < n + 700) begin
					if ($urandom_range(0, 15) == 0)
						send_fields(action_t'($urandom_range(0, 3)), OP_READ,
							24'($urandom), 16'($urandom), 8'($urandom));
					else if (ph == PH_PROG_DATA)
						send_fields(ACT_DATA, operation_t'($urandom_range(0, 3)),
							24'($urandom), 16'($urandom), 8'($urandom));
					else
						send_fields(ACT_REPLY, operation_t'($urandom_range(0, 3)),
							24'($urandom), 16'($urandom),
							($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00);
					cnt++;
				end
				finish_sequence();
			end
		end
		drain();
	endtask

	initial begin
		cfg = '{8'h02, 8'h03, 8'h06, 8'h05, 8'h20, 8'h9F, 8'hFF, 8'h01};
		ph = PH_IDLE;
		faddr = '0;
		remain = '0;
		page_left = '0;
		ident_acc = '0;
		ident_cnt = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		set_all_regs(8'h00);
		test_random(120);
		set_all_regs(8'hFF);
		write_reg(R_BUSY, 8'hFF);
		test_random(120);
		for (int i = 0; i < 8; i++) write_reg(i[2:0], 8'h00);
		write_reg(R_BUSY, 8'h80);
		idle_off = 1'b1;
		test_random(120);
		drain();
		$display("%0d requests, %0d results; %0d pages, %0d sectors, %0d identifiers",
			transfers, results_seen, pages_done, sectors_done, idents_done);
		if (mismatches == 0 && frames_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
